/* design/kti_pkg.sv */
// ----------------------------------------------------------------------------
// kti_pkg
// Shared constants and types of the keyframe table interpolator.
// ----------------------------------------------------------------------------
package kti_pkg;

    localparam int KEYS = 16;
    localparam int KW   = 4;
    localparam int PTS  = 16;
    localparam int PW   = 4;
    localparam int AW   = KW + PW;

    typedef enum logic [1:0] {
        F_STAGE = 2'd0,
        F_ADD   = 2'd1,
        F_QUERY = 2'd2,
        F_DEL   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_NOMATCH = 2'd3
    } t_status;

    localparam logic [2:0] REG_TOL = 3'd0;

endpackage

/* design/kti_point_ram.sv */
// ----------------------------------------------------------------------------
// kti_point_ram
// Point store: one write port and two registered read ports.
// ----------------------------------------------------------------------------
module kti_point_ram import kti_pkg::*; (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [63:0]   i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [63:0]   o_rdata_a,
    output logic [63:0]   o_rdata_b
);

    logic [63:0] r_mem [KEYS*PTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

/* design/kti_divider.sv */
// ----------------------------------------------------------------------------
// kti_divider
// Restoring divider giving floor(num * 2^31 / den) for num <= den.
// ----------------------------------------------------------------------------
module kti_divider import kti_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quot
);

    logic [31:0] r_rem;
    logic [31:0] r_den;
    logic [4:0]  r_cnt;
    logic        r_run;
    logic [32:0] rem2;
    logic [32:0] sub;

    assign rem2 = {r_rem, 1'b0};
    assign sub  = rem2 - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= 5'd31;
                r_den <= i_den;
                if (i_num >= i_den) begin
                    r_rem  <= i_num - i_den;
                    o_quot <= 32'd1;
                end else begin
                    r_rem  <= i_num;
                    o_quot <= 32'd0;
                end
            end else if (r_run) begin
                if (!sub[32]) begin
                    r_rem  <= sub[31:0];
                    o_quot <= {o_quot[30:0], 1'b1};
                end else begin
                    r_rem  <= rem2[31:0];
                    o_quot <= {o_quot[30:0], 1'b0};
                end
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_run  <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

endmodule

/* design/keyframe_table_interpolator.sv */
// ----------------------------------------------------------------------------
// keyframe_table_interpolator
// Time-ordered keyframe table with staging, insert, delete and linear query.
// ----------------------------------------------------------------------------
// A stage word is absorbed in the accept cycle; add scans the order list and then
// copies the staged points into the point memory; delete scans the order list.
// A query scans, waits for the serial divider when it interpolates, passes the
// setup state, then reads, differences, multiplies and outputs each point in turn.
// Busy stays high until the last result word; results cannot be stalled.
// Reset empties the table and clears the staged points.
module keyframe_table_interpolator import kti_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_func,
    input  logic signed [31:0] i_time_value,
    input  logic [7:0]         i_curve_tag,
    input  logic [4:0]         i_point_count,
    input  logic [3:0]         i_point_index,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic [7:0]         o_out_curve_tag,
    output logic [4:0]         o_out_point_count,
    output logic [3:0]         o_out_index,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic               o_last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_SCAN  = 8'b00000010,
        S_COPY  = 8'b00000100,
        S_DIV   = 8'b00001000,
        S_START = 8'b00010000,
        S_RD    = 8'b00100000,
        S_DIFF  = 8'b01000000,
        S_OUT   = 8'b10000000
    } t_state;

    t_state             r_state;
    logic               r_mul;
    logic [1:0]         r_func;
    logic signed [31:0] r_tv;
    logic [7:0]         r_cid;
    logic [4:0]         r_pcnt;
    logic [15:0]        r_tol;
    logic [4:0]         r_count;
    logic [KW-1:0]      r_order [KEYS];
    logic signed [31:0] r_time  [KEYS];
    logic [7:0]         r_curve [KEYS];
    logic [4:0]         r_pts   [KEYS];
    logic [31:0]        r_stx   [PTS];
    logic [31:0]        r_sty   [PTS];
    logic [4:0]         r_i;
    logic [PW-1:0]      r_j;
    logic [KW-1:0]      r_slot;
    logic [KW-1:0]      r_src;
    logic [KW-1:0]      r_oth;
    logic signed [31:0] r_prev_time;
    logic [KW-1:0]      r_prev_slot;
    logic [31:0]        r_num;
    logic [31:0]        r_den;
    logic               r_div_go;
    logic [31:0]        r_t;
    logic [32:0]        r_magx, r_magy;
    logic               r_negx, r_negy;
    logic [31:0]        r_p1x, r_p1y;
    logic [48:0]        r_phx, r_phy;
    logic [47:0]        r_plx, r_ply;

    logic               div_done;
    logic [31:0]        div_quot;
    logic [63:0]        rd_a, rd_b;
    logic               we;
    logic [KW-1:0]      scan_slot;
    logic signed [31:0] scan_time;
    logic               in_range;
    logic signed [32:0] tdiff;
    logic [32:0]        absd;
    logic               scan_go;
    logic signed [32:0] dx, dy;
    logic [64:0]        sumx, sumy;
    logic [33:0]        sx, sy;
    logic [33:0]        resx, resy;
    logic [4:0]         src_cnt;
    logic               cfg_wr;

    kti_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign we = (r_state == S_COPY);

    kti_point_ram u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   ({r_slot, r_j}),
        .i_wdata   ({r_stx[r_j], r_sty[r_j]}),
        .i_raddr_a ({r_src, r_j}),
        .i_raddr_b ({r_oth, r_j}),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    assign busy   = (r_state != S_IDLE);
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr == REG_TOL) ? {16'd0, r_tol} : 32'd0;

    assign scan_slot = r_order[r_i[KW-1:0]];
    assign scan_time = r_time[scan_slot];
    assign in_range  = (r_i < r_count);
    assign tdiff     = {scan_time[31], scan_time} - {r_tv[31], r_tv};
    assign absd      = tdiff[32] ? 33'(-tdiff) : 33'(tdiff);
    assign scan_go   = in_range && ((r_func == F_DEL) ? !(absd < {17'd0, r_tol})
                                                      : (scan_time < r_tv));

    assign dx = {rd_b[63], rd_b[63:32]} - {rd_a[63], rd_a[63:32]};
    assign dy = {rd_b[31], rd_b[31:0]} - {rd_a[31], rd_a[31:0]};
    assign sumx = {r_phx, 16'd0} + {17'd0, r_plx} + 65'(64'h4000_0000);
    assign sumy = {r_phy, 16'd0} + {17'd0, r_ply} + 65'(64'h4000_0000);
    assign sx   = sumx[64:31];
    assign sy   = sumy[64:31];
    assign resx = r_negx ? {{2{r_p1x[31]}}, r_p1x} - sx : {{2{r_p1x[31]}}, r_p1x} + sx;
    assign resy = r_negy ? {{2{r_p1y[31]}}, r_p1y} - sy : {{2{r_p1y[31]}}, r_p1y} + sy;
    assign src_cnt = r_pts[r_src];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_tol    <= 16'd66;
            r_count  <= '0;
            r_div_go <= 1'b0;
            r_mul    <= 1'b0;
            o_valid  <= 1'b0;
            for (int k = 0; k < KEYS; k++) begin
                r_order[k] <= KW'(k);
            end
            for (int k = 0; k < PTS; k++) begin
                r_stx[k] <= '0;
                r_sty[k] <= '0;
            end
        end else begin
            o_valid  <= 1'b0;
            r_div_go <= 1'b0;
            if (cfg_wr && paddr == REG_TOL) begin
                r_tol <= pwdata[15:0];
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_func <= i_func;
                        r_tv   <= i_time_value;
                        r_cid  <= i_curve_tag;
                        r_pcnt <= (i_point_count > 5'(PTS)) ? 5'(PTS) : i_point_count;
                        r_i    <= '0;
                        o_out_curve_tag   <= '0;
                        o_out_point_count <= '0;
                        o_out_index       <= '0;
                        o_out_x           <= '0;
                        o_out_y           <= '0;
                        o_last            <= 1'b1;
                        if (i_func == F_STAGE) begin
                            r_stx[i_point_index] <= i_point_x;
                            r_sty[i_point_index] <= i_point_y;
                        end else if (i_func == F_QUERY && r_count == 5'd0) begin
                            o_valid  <= 1'b1;
                            o_status <= ST_EMPTY;
                        end else if (i_func == F_ADD && r_count >= 5'(KEYS)) begin
                            o_valid  <= 1'b1;
                            o_status <= ST_FULL;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (scan_go) begin
                        r_i         <= r_i + 5'd1;
                        r_prev_time <= scan_time;
                        r_prev_slot <= scan_slot;
                    end else if (r_func == F_ADD) begin
                        r_slot  <= r_order[r_count[KW-1:0]];
                        r_j     <= '0;
                        r_state <= S_COPY;
                    end else if (r_func == F_DEL) begin
                        o_valid <= 1'b1;
                        if (!in_range) begin
                            o_status <= ST_NOMATCH;
                        end else begin
                            o_status <= ST_OK;
                            for (int k = 0; k < KEYS - 1; k++) begin
                                if (5'(k) >= r_i && 5'(k) + 5'd1 < r_count) begin
                                    r_order[k] <= r_order[k + 1];
                                end
                            end
                            r_order[KW'(r_count - 5'd1)] <= scan_slot;
                            r_count <= r_count - 5'd1;
                        end
                        r_state <= S_IDLE;
                    end else if (r_i == 5'd0) begin
                        r_src   <= scan_slot;
                        r_oth   <= scan_slot;
                        r_t     <= '0;
                        r_state <= S_START;
                    end else if (!in_range) begin
                        r_src   <= r_prev_slot;
                        r_oth   <= r_prev_slot;
                        r_t     <= '0;
                        r_state <= S_START;
                    end else begin
                        r_src    <= r_prev_slot;
                        r_oth    <= scan_slot;
                        r_num    <= 32'(r_tv - r_prev_time);
                        r_den    <= 32'(scan_time - r_prev_time);
                        r_div_go <= 1'b1;
                        r_state  <= S_DIV;
                    end
                end
                S_COPY: begin
                    r_j <= r_j + PW'(1);
                    if (r_j == PW'(PTS - 1)) begin
                        r_time[r_slot]  <= r_tv;
                        r_curve[r_slot] <= r_cid;
                        r_pts[r_slot]   <= r_pcnt;
                        for (int k = 1; k < KEYS; k++) begin
                            if (5'(k) > r_i && 5'(k) <= r_count) begin
                                r_order[k] <= r_order[k - 1];
                            end
                        end
                        r_order[r_i[KW-1:0]] <= r_slot;
                        r_count  <= r_count + 5'd1;
                        o_valid  <= 1'b1;
                        o_status <= ST_OK;
                        r_state  <= S_IDLE;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_t     <= div_quot;
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_j <= '0;
                    if (src_cnt == 5'd0) begin
                        o_valid         <= 1'b1;
                        o_status        <= ST_OK;
                        o_out_curve_tag <= r_curve[r_src];
                        r_state         <= S_IDLE;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    if (!r_mul) begin
                        r_p1x  <= rd_a[63:32];
                        r_p1y  <= rd_a[31:0];
                        r_negx <= dx[32];
                        r_negy <= dy[32];
                        r_magx <= dx[32] ? 33'(-dx) : 33'(dx);
                        r_magy <= dy[32] ? 33'(-dy) : 33'(dy);
                        r_mul  <= 1'b1;
                    end else begin
                        r_phx   <= r_magx[32:16] * r_t;
                        r_plx   <= r_magx[15:0] * r_t;
                        r_phy   <= r_magy[32:16] * r_t;
                        r_ply   <= r_magy[15:0] * r_t;
                        r_mul   <= 1'b0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    o_valid           <= 1'b1;
                    o_status          <= ST_OK;
                    o_out_curve_tag   <= r_curve[r_src];
                    o_out_point_count <= src_cnt;
                    o_out_index       <= r_j;
                    o_out_x           <= resx[31:0];
                    o_out_y           <= resy[31:0];
                    o_last            <= ({1'b0, r_j} + 5'd1 == src_cnt);
                    r_j               <= r_j + PW'(1);
                    if ({1'b0, r_j} + 5'd1 == src_cnt) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 5'(KEYS))
        else $error("entry count beyond table depth");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_last)
        else $error("status word without last");

    a_copy_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_COPY |-> r_count < 5'(KEYS))
        else $error("copy into full table");

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("divider finished outside its wait state");

endmodule
